FILE: design/observation_history_buffer_assert.svh
// ---------------------------------------------------------------------------
// observation_history_buffer_assert.svh
// Assertion macros for the observation history buffer.
// ---------------------------------------------------------------------------
`ifndef OBSERVATION_HISTORY_BUFFER_ASSERT_SVH
`define OBSERVATION_HISTORY_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define OHB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OHB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OHB_ASSERT(label, prop, msg)
`define OHB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: design/ohb_pkg.sv
// ---------------------------------------------------------------------------
// ohb_pkg
// Shared types and constants of the observation history buffer.
// ---------------------------------------------------------------------------
package ohb_pkg;

  localparam int ENV_COUNT_DEF     = 4;
  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int OBS_MAX_DEF       = 16;
  localparam int NUM_TERMS_DEF     = 4;
  localparam int STEP_LIST_MAX_DEF = 4;
  localparam int TERM_REGS         = 4;

  // action codes
  localparam logic [2:0] ACT_LOAD_ELEM   = 3'd0;
  localparam logic [2:0] ACT_INSERT      = 3'd1;
  localparam logic [2:0] ACT_RESET_ENV   = 3'd2;
  localparam logic [2:0] ACT_LOAD_STEP   = 3'd3;
  localparam logic [2:0] ACT_READ        = 3'd4;
  localparam logic [2:0] ACT_CLR_STAGE   = 3'd5;
  localparam logic [2:0] ACT_CLR_STEPS   = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_BAD_ENV  = 2'd2;
  localparam logic [1:0] ST_NO_STEP  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ORDER   = 3'd0;
  localparam logic [2:0] REG_DIM0    = 3'd1;
  localparam logic [2:0] REG_DIM3    = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] elem_value;
    logic [2:0]  env_index;
    logic [3:0]  step_index;
  } cmd_t;

  typedef struct packed {
    logic        is_status;
    logic [31:0] out_value;
    logic [1:0]  status_code;
    logic        last_item;
  } result_t;

endpackage

FILE: design/observation_history_buffer.sv
// ---------------------------------------------------------------------------
// observation_history_buffer
// Per-environment history of staged observation vectors, held in RAM.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         cmd (ohb_pkg::cmd_t)
// result    out        result_valid, 1 cycle result (ohb_pkg::result_t)
// config    in         cfg_we                cfg_index, cfg_data
//
// Loads, clears and rejected commands leave busy low. Insert writes
// ENV_COUNT*OBS_MAX words (64) with busy high, one history write a cycle.
// Reset env writes HISTORY_DEPTH*min(total, staged) words (up to 128), busy high.
// A read passes S_RSTEP per step run visited, S_RWAIT and S_REMIT per word
// (RAM latency) and S_RSTEP once more to finish.
// After reset a clearing pass zeroes all 2^(EB+HB+OB) words (512) of the
// history RAM with busy high. Results are registered and cannot be stalled.
// ---------------------------------------------------------------------------
module observation_history_buffer #(
  parameter int ENV_COUNT     = ohb_pkg::ENV_COUNT_DEF,
  parameter int HISTORY_DEPTH = ohb_pkg::HISTORY_DEPTH_DEF,
  parameter int OBS_MAX       = ohb_pkg::OBS_MAX_DEF,
  parameter int NUM_TERMS     = ohb_pkg::NUM_TERMS_DEF,
  parameter int STEP_LIST_MAX = ohb_pkg::STEP_LIST_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ohb_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              result_valid,
  output ohb_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [4:0]        cfg_data
);

`include "observation_history_buffer_assert.svh"

  localparam int EB = (ENV_COUNT > 1) ? $clog2(ENV_COUNT) : 1;
  localparam int HB = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int OB = (OBS_MAX > 1) ? $clog2(OBS_MAX) : 1;
  localparam int SB = (STEP_LIST_MAX > 1) ? $clog2(STEP_LIST_MAX) : 1;
  localparam int CB = $clog2(STEP_LIST_MAX + 1);
  localparam int KB = $clog2(OBS_MAX + 1);
  localparam int AB = EB + HB + OB;
  localparam int NT = (NUM_TERMS < ohb_pkg::TERM_REGS) ? NUM_TERMS : ohb_pkg::TERM_REGS;
  localparam int TB = 2;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_INSERT = 3'd2;
  localparam logic [2:0] S_RESET  = 3'd3;
  localparam logic [2:0] S_RSTEP  = 3'd4;
  localparam logic [2:0] S_RWAIT  = 3'd5;
  localparam logic [2:0] S_REMIT  = 3'd6;

  // configuration registers
  logic       order_by_term;
  logic [4:0] term_dim [ohb_pkg::TERM_REGS];
  logic [8:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_by_term <= 1'b0;
      for (int i = 0; i < ohb_pkg::TERM_REGS; i++) term_dim[i] <= 5'd4;
    end else if (cfg_we) begin
      if (cfg_index == ohb_pkg::REG_ORDER) order_by_term <= cfg_data[0];
      else if (cfg_index inside {[ohb_pkg::REG_DIM0:ohb_pkg::REG_DIM3]})
        term_dim[2'(cfg_index - ohb_pkg::REG_DIM0)] <= cfg_data;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NT; i++) total = total + 9'(term_dim[i]);
  end

  // control state
  logic [2:0]     state;
  logic [HB-1:0]  newest_slot;
  logic [KB-1:0]  staged_count;
  logic           staged_overflow;
  logic [CB-1:0]  step_count;
  logic [3:0]     step_list [STEP_LIST_MAX];
  logic [AB-1:0]  clr_addr;
  logic [EB-1:0]  env_q;
  logic [HB-1:0]  slot_q;
  logic [OB-1:0]  elem_q;
  logic [KB-1:0]  lim_q;
  logic [CB-1:0]  s_q;
  logic [TB-1:0]  t_q;
  logic [8:0]     off_q;
  logic [8:0]     j_q;
  logic [8:0]     jend_q;
  logic           held;
  logic [31:0]    hold_word;

  // staging RAM and history RAM
  logic          st_we;
  logic [OB-1:0] st_waddr, st_raddr;
  logic [31:0]   st_rdata;
  logic          h_we;
  logic [AB-1:0] h_waddr, h_raddr;
  logic [31:0]   h_wdata, h_rdata;

  ohb_ram #(.WIDTH(32), .DEPTH(1 << OB)) u_stage (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(cmd.elem_value),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  ohb_ram #(.WIDTH(32), .DEPTH(1 << AB)) u_hist (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  logic accept;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  logic          env_ok;
  logic [3:0]    cur_step;
  logic [HB:0]   slot_sum;
  logic [HB-1:0] rd_slot;
  logic [8:0]    kend;
  logic [8:0]    run_first;
  logic [8:0]    run_end;
  assign env_ok   = 32'(cmd.env_index) < ENV_COUNT;
  assign cur_step = step_list[s_q[SB-1:0]];
  assign slot_sum = (HB+1)'(newest_slot) + (HB+1)'(cur_step);
  assign rd_slot  = (slot_sum >= (HB+1)'(HISTORY_DEPTH)) ?
                    HB'(slot_sum - (HB+1)'(HISTORY_DEPTH)) : HB'(slot_sum);
  // first element and end of the current run, clipped at OBS_MAX
  assign kend      = order_by_term ? off_q + 9'(term_dim[t_q]) : total;
  assign run_first = order_by_term ? off_q : 9'd0;
  assign run_end   = (kend < 9'(OBS_MAX)) ? kend : 9'(OBS_MAX);

  // staging writes happen only on a load element with room
  assign st_we    = accept && cmd.action == ohb_pkg::ACT_LOAD_ELEM &&
                    32'(staged_count) < OBS_MAX;
  assign st_waddr = OB'(staged_count);

  // history write data: pipelined a register behind the staging read
  logic          pw_v;
  logic [AB-1:0] pw_addr;
  logic          pw_zero;
  assign h_we    = (state == S_CLEAR) || pw_v;
  assign h_waddr = (state == S_CLEAR) ? clr_addr : pw_addr;
  assign h_wdata = (state == S_CLEAR || pw_zero) ? 32'd0 : st_rdata;

  logic step_ok;
  assign step_ok = 32'(cur_step) < HISTORY_DEPTH;

  assign st_raddr = elem_q;
  assign h_raddr  = {env_q, rd_slot, OB'(j_q)};

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    pw_v         <= 1'b0;
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      newest_slot     <= '0;
      staged_count    <= '0;
      staged_overflow <= 1'b0;
      step_count      <= '0;
      result          <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (cmd.action)
              ohb_pkg::ACT_LOAD_ELEM: begin
                if (32'(staged_count) < OBS_MAX) staged_count <= staged_count + 1'b1;
                else staged_overflow <= 1'b1;
              end
              ohb_pkg::ACT_INSERT: begin
                if (staged_overflow || 9'(staged_count) != total) begin
                  result_valid <= 1'b1;
                  result <= '{1'b1, 32'd0, ohb_pkg::ST_LENGTH, 1'b1};
                end else begin
                  newest_slot <= (newest_slot == '0) ? HB'(HISTORY_DEPTH - 1)
                                                     : newest_slot - 1'b1;
                  env_q  <= '0;
                  elem_q <= '0;
                  lim_q  <= staged_count;
                  state  <= S_INSERT;
                end
              end
              ohb_pkg::ACT_RESET_ENV: begin
                if (!env_ok) begin
                  result_valid <= 1'b1;
                  result <= '{1'b1, 32'd0, ohb_pkg::ST_BAD_ENV, 1'b1};
                end else begin
                  env_q  <= EB'(cmd.env_index);
                  slot_q <= '0;
                  elem_q <= '0;
                  lim_q  <= (9'(staged_count) < total) ? staged_count : KB'(total);
                  state  <= S_RESET;
                end
              end
              ohb_pkg::ACT_LOAD_STEP: begin
                if (32'(step_count) < STEP_LIST_MAX) begin
                  step_list[step_count[SB-1:0]] <= cmd.step_index;
                  step_count <= step_count + 1'b1;
                end
              end
              ohb_pkg::ACT_READ: begin
                if (!env_ok) begin
                  result_valid <= 1'b1;
                  result <= '{1'b1, 32'd0, ohb_pkg::ST_BAD_ENV, 1'b1};
                end else begin
                  env_q <= EB'(cmd.env_index);
                  s_q   <= '0;
                  t_q   <= '0;
                  off_q <= '0;
                  held  <= 1'b0;
                  state <= S_RSTEP;
                end
              end
              ohb_pkg::ACT_CLR_STAGE: begin
                staged_count    <= '0;
                staged_overflow <= 1'b0;
              end
              ohb_pkg::ACT_CLR_STEPS: step_count <= '0;
              default: ;
            endcase
          end
        end
        // one word per cycle into slot newest of every env
        S_INSERT: begin
          pw_v    <= 1'b1;
          pw_addr <= {env_q, newest_slot, elem_q};
          pw_zero <= !(KB'(elem_q) < lim_q);
          if (32'(elem_q) == OBS_MAX - 1) begin
            elem_q <= '0;
            if (32'(env_q) == ENV_COUNT - 1) begin
              state        <= S_IDLE;
              result_valid <= 1'b1;
              result <= '{1'b1, 32'd0, ohb_pkg::ST_OK, 1'b1};
            end else env_q <= env_q + 1'b1;
          end else elem_q <= elem_q + 1'b1;
        end
        // first lim words of every slot of one env
        S_RESET: begin
          if (lim_q == '0) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            result <= '{1'b1, 32'd0, ohb_pkg::ST_OK, 1'b1};
          end else begin
            pw_v    <= 1'b1;
            pw_addr <= {env_q, slot_q, elem_q};
            pw_zero <= 1'b0;
            if (KB'(elem_q) == lim_q - 1'b1) begin
              elem_q <= '0;
              if (32'(slot_q) == HISTORY_DEPTH - 1) begin
                state        <= S_IDLE;
                result_valid <= 1'b1;
                result <= '{1'b1, 32'd0, ohb_pkg::ST_OK, 1'b1};
              end else slot_q <= slot_q + 1'b1;
            end else elem_q <= elem_q + 1'b1;
          end
        end
        // pick the next step / term run, or finish the read
        S_RSTEP: begin
          if (s_q == step_count) begin
            if (order_by_term && 32'(t_q) < NT - 1) begin
              t_q   <= t_q + 1'b1;
              off_q <= off_q + 9'(term_dim[t_q]);
              s_q   <= '0;
            end else begin
              // the held word is the final one; nothing held means no word
              state        <= S_IDLE;
              result_valid <= 1'b1;
              if (held) result <= '{1'b0, hold_word, ohb_pkg::ST_OK, 1'b1};
              else result <= '{1'b1, 32'd0, ohb_pkg::ST_NO_STEP, 1'b1};
            end
          end else if (!step_ok || run_first >= run_end) begin
            s_q <= s_q + 1'b1;
          end else begin
            j_q    <= run_first;
            jend_q <= run_end;
            state  <= S_RWAIT;
          end
        end
        // history address for j_q is sampled here
        S_RWAIT: state <= S_REMIT;
        // word arrives; the previous word goes out, this one is held so
        // the final word can carry last_item
        S_REMIT: begin
          if (held) begin
            result_valid <= 1'b1;
            result <= '{1'b0, hold_word, ohb_pkg::ST_OK, 1'b0};
          end
          held      <= 1'b1;
          hold_word <= h_rdata;
          if (j_q + 9'd1 == jend_q) begin
            s_q   <= s_q + 1'b1;
            state <= S_RSTEP;
          end else begin
            j_q   <= j_q + 9'd1;
            state <= S_RWAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OHB_ASSERT(a_last_idle, result_valid && result.last_item |-> !busy, "last result while busy")
  `OHB_ASSERT(a_status_zero, result_valid && result.is_status |-> result.out_value == 32'd0, "status with data")
  `OHB_ASSERT(a_stage_bound, 1'b1 |-> 32'(staged_count) <= OBS_MAX, "staging overrun")
  `OHB_ASSERT(a_steps_bound, 1'b1 |-> 32'(step_count) <= STEP_LIST_MAX, "step list overrun")
  `OHB_ASSERT_ALWAYS(a_rst_quiet, rst |=> !result_valid, "result after reset")

endmodule

FILE: design/ohb_ram.sv
// ---------------------------------------------------------------------------
// ohb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module ohb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
